>>> hdl/gdi_pkg.sv
package gdi_pkg;

  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned MASK_W       = 7;

  // register indexes (byte address / 4)
  localparam logic REG_WEEKEND_MASK = 1'b0;

  localparam logic [MASK_W-1:0] WEEKEND_MASK_RST = 7'd96;

  // reciprocal of 100: exact for operands below 199728
  localparam int unsigned RECIP_SHIFT  = 24;
  localparam logic [31:0] RECIP_100    = 32'd167773;

  typedef struct packed {
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [13:0] year_number;
  } date_t;

  typedef struct packed {
    logic [2:0] weekday;
    logic       leap_year;
    logic [4:0] month_length;
    logic       is_weekend;
    logic [2:0] days_to_week_end;
    logic [4:0] days_to_month_end;
    logic [8:0] days_to_year_end;
    logic       date_invalid;
  } info_t;

  // floor(31 * mm / 12) for the shifted month mm (1 = March .. 12 = February)
  function automatic logic [5:0] month_offset(input logic [3:0] mm);
    logic [5:0] r;
    unique case (mm)
      4'd1:    r = 6'd2;
      4'd2:    r = 6'd5;
      4'd3:    r = 6'd7;
      4'd4:    r = 6'd10;
      4'd5:    r = 6'd12;
      4'd6:    r = 6'd15;
      4'd7:    r = 6'd18;
      4'd8:    r = 6'd20;
      4'd9:    r = 6'd23;
      4'd10:   r = 6'd25;
      4'd11:   r = 6'd28;
      4'd12:   r = 6'd31;
      4'd13:   r = 6'd33;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  // days in month for a common year; 0 for a month code out of range
  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/gdi_pipe.sv
module gdi_pipe
  import gdi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [MASK_W-1:0] weekend_mask,
  input  logic              date_valid,
  output logic              date_ready,
  input  date_t             date,
  output logic              info_valid,
  input  logic              info_ready,
  output info_t             info
);

  // stage 1: shifted calendar and reciprocal products
  logic        s1_valid;
  logic [4:0]  s1_d;
  logic [3:0]  s1_m;
  logic [13:0] s1_y;
  logic [14:0] s1_yy;
  logic [3:0]  s1_mm;
  logic [31:0] s1_p_yy;
  logic [31:0] s1_p_y;

  // stage 2: congruence sum and calendar fields
  logic        s2_valid;
  logic [14:0] s2_sum;
  logic        s2_leap;
  logic [4:0]  s2_mlen;
  logic [4:0]  s2_to_month;
  logic [8:0]  s2_to_year;
  logic        s2_invalid;

  logic ld1, ld2, ld3;

  assign ld3        = !info_valid || info_ready;
  assign ld2        = !s2_valid || ld3;
  assign ld1        = !s1_valid || ld2;
  assign date_ready = ld1;

  // ---------------- stage 1 ----------------
  logic        shift_c;
  logic [14:0] yy_c;
  logic [3:0]  mm_c;

  always_comb begin
    shift_c = (date.month_number <= 4'd2);
    yy_c    = 15'(date.year_number) + 15'd400 - 15'(shift_c);
    mm_c    = shift_c ? date.month_number + 4'd10 : date.month_number - 4'd2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ld1) begin
      s1_valid <= date_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_d    <= date.day_of_month;
      s1_m    <= date.month_number;
      s1_y    <= date.year_number;
      s1_yy   <= yy_c;
      s1_mm   <= mm_c;
      s1_p_yy <= 32'(yy_c) * RECIP_100;
      s1_p_y  <= 32'(date.year_number) * RECIP_100;
    end
  end

  // ---------------- stage 2 ----------------
  logic [7:0]  q_yy;
  logic [7:0]  q_y;
  logic [13:0] q_y_x100;
  logic        div100;
  logic        leap_c;
  logic        month_ok;
  logic [4:0]  mlen_c;
  logic        invalid_c;
  logic [8:0]  before_c;
  logic [14:0] sum_c;

  always_comb begin
    q_yy     = s1_p_yy[RECIP_SHIFT +: 8];
    q_y      = s1_p_y[RECIP_SHIFT +: 8];
    q_y_x100 = (14'(q_y) << 6) + (14'(q_y) << 5) + (14'(q_y) << 2);
    div100   = (q_y_x100 == s1_y);
    leap_c   = ((s1_y[1:0] == 2'd0) && !div100) || (div100 && (q_y[1:0] == 2'd0));
    month_ok = (s1_m >= 4'd1) && (s1_m <= 4'd12);
    mlen_c   = month_days(s1_m) + ((s1_m == 4'd2) ? 5'(leap_c) : 5'd0);
    invalid_c = !month_ok || (s1_d == 5'd0) || (s1_d > mlen_c);
    before_c = days_before(s1_m) + ((s1_m > 4'd2) ? 9'(leap_c) : 9'd0);
    sum_c    = 15'(s1_d) + s1_yy + 15'(s1_yy[14:2]) - 15'(q_yy) + 15'(q_yy[7:2])
             + 15'(month_offset(s1_mm));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ld2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_sum      <= sum_c;
      s2_leap     <= leap_c;
      s2_mlen     <= mlen_c;
      s2_invalid  <= invalid_c;
      s2_to_month <= invalid_c ? 5'd0 : mlen_c - s1_d;
      s2_to_year  <= invalid_c ? 9'd0 : 9'd365 + 9'(leap_c) - before_c - 9'(s1_d);
    end
  end

  // ---------------- stage 3: mod 7 and output register ----------------
  // 8 = 1 mod 7: fold octal digits, then one conditional subtract
  logic [5:0]  fold1;
  logic [3:0]  fold2;
  logic [2:0]  wd_c;
  logic [7:0]  mask_ext;

  always_comb begin
    fold1 = 6'(s2_sum[2:0]) + 6'(s2_sum[5:3]) + 6'(s2_sum[8:6])
          + 6'(s2_sum[11:9]) + 6'(s2_sum[14:12]);
    fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
    wd_c  = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
    mask_ext = {1'b0, weekend_mask};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      info_valid <= 1'b0;
    end else if (ld3) begin
      info_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      info.weekday           <= wd_c;
      info.leap_year         <= s2_leap;
      info.month_length      <= s2_mlen;
      info.is_weekend        <= mask_ext[wd_c];
      info.days_to_week_end  <= 3'd6 - wd_c;
      info.days_to_month_end <= s2_to_month;
      info.days_to_year_end  <= s2_to_year;
      info.date_invalid      <= s2_invalid;
    end
  end

endmodule

>>> hdl/gregorian_date_info.sv
// Gregorian date information unit.
// The date channel (date_valid / date_ready / date) carries day, month and year;
// the info channel (info_valid / info_ready / info) returns one result per date:
// weekday (0 = Sunday), leap flag, month length, weekend flag, days to Saturday,
// days left in the month and in the year, and an invalid-date flag.
// The weekend_mask register sits at APB byte address 0 (pready always high,
// writes land on the access cycle); byte addresses 4 to 7 read as zero.
// Pipeline: a date is registered in stage 1 (reciprocal multiplies), then in
// stage 2 (congruence sum and calendar tables), then in stage 3 (mod-7 fold
// into the output register), which drives info.
// Throughput: one date per cycle unless info is stalled; each stage has its own
// valid bit, so the block keeps taking dates into empty stages while a result
// waits on info_ready. When the receiver stalls, the pipe fills up and date_ready
// drops once all three stages hold results; nothing is lost or repeated.
// Synchronous reset empties the pipe and sets weekend_mask to Friday+Saturday.
module gregorian_date_info
  import gdi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  date_valid,
  output logic                  date_ready,
  input  date_t                 date,
  output logic                  info_valid,
  input  logic                  info_ready,
  output info_t                 info
);

  logic [MASK_W-1:0] weekend_mask;
  logic              reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      weekend_mask <= WEEKEND_MASK_RST;
    end else if (psel && penable && pwrite && (reg_idx == REG_WEEKEND_MASK)) begin
      weekend_mask <= pwdata[MASK_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_WEEKEND_MASK) begin
      prdata = CFG_DATA_W'(weekend_mask);
    end
  end

  gdi_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .weekend_mask (weekend_mask),
    .date_valid   (date_valid),
    .date_ready   (date_ready),
    .date         (date),
    .info_valid   (info_valid),
    .info_ready   (info_ready),
    .info         (info)
  );

  logic [7:0] mask_chk;
  assign mask_chk = {1'b0, weekend_mask};

  a_reset_empty: assert property (@(posedge clk) rst |=> !info_valid)
    else $error("info_valid high right after reset");

  a_weekend_flag: assert property (@(posedge clk) disable iff (rst)
    info_valid |-> (info.is_weekend == mask_chk[info.weekday]))
    else $error("is_weekend disagrees with weekend_mask");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !date_ready |-> (info_valid && !info_ready))
    else $error("date_ready low without a stalled result");

endmodule
